// File: src/gda_pkg.sv
// ----------------------------------------------------------------------------
// gda_pkg: shared types and constants for the Gregorian date adder
// Sequencer states, action and error codes, and calendar helper functions.
// ----------------------------------------------------------------------------
package gda_pkg;

  // Stream payload widths, padded to whole bytes.
  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 24;

  // Working year register: holds year_in plus amount, or one past the limit.
  localparam int YEAR_W   = 17;
  localparam int REM_W    = 18;   // days left to add: up to 7 * 32767
  localparam int RES_W    = 9;    // year residue modulo 400

  localparam int MOD_BASE  = 400;
  localparam int MOD_STEPS = 8;
  localparam int STEP_W    = $clog2(MOD_STEPS);

  localparam logic [1:0] ACT_DAYS   = 2'd0;
  localparam logic [1:0] ACT_WEEKS  = 2'd1;
  localparam logic [1:0] ACT_MONTHS = 2'd2;
  localparam logic [1:0] ACT_YEARS  = 2'd3;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_DAY  = 2'd1;
  localparam logic [1:0] ERR_YEAR = 2'd2;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_CHECK,
    ST_DAYS,
    ST_MONTHS,
    ST_YFIX,
    ST_DONE
  } state_t;

  // Leap year from the year's residue modulo 400.
  function automatic logic leap_of(input logic [RES_W-1:0] res);
    return (res == 9'd0) ||
           ((res[1:0] == 2'd0) && (res != 9'd100) && (res != 9'd200) && (res != 9'd300));
  endfunction

  // Length of a month; zero for a month code outside 1..12.
  function automatic logic [4:0] month_days(input logic leap, input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// File: src/gda_mod400.sv
// ----------------------------------------------------------------------------
// gda_mod400: iterative year residue unit
// Reduces a year modulo 400 by restoring compare and subtract, one multiple
// of 400 per cycle, starting from 400 * 128 and halving.
// ----------------------------------------------------------------------------
module gda_mod400 (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [gda_pkg::YEAR_W-1:0] value,
  output logic                       done,
  output logic [gda_pkg::RES_W-1:0]  res
);
  import gda_pkg::*;

  logic [YEAR_W-1:0] acc;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic [YEAR_W-1:0] sub;

  assign sub = YEAR_W'(MOD_BASE) << step;
  assign res = acc[RES_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else begin
      done <= busy && (step == '0);
      if (busy && (step == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= value;
      step <= STEP_W'(MOD_STEPS - 1);
    end else if (busy) begin
      if (acc >= sub) begin
        acc <= acc - sub;
      end
      step <= step - 1'b1;
    end
  end

endmodule

// File: src/gregorian_date_adder.sv
// ----------------------------------------------------------------------------
// gregorian_date_adder: adds days, weeks, months or years to a date
// A small sequencer walks the calendar one month per cycle and uses an
// iterative modulo-400 unit for the leap rule.
//
//   Channel   Direction  Fields (lowest bit first)
//   s_        request    tuser: action; tdata: year_in, month_in, day_in, amount
//   m_        result     tuser: error_code; tdata: year_out, month_out, day_out
//
// Each request first takes the residue of the start year; then days and
// weeks step once per month boundary crossed, months step once per month
// added, and years take a second residue pass. The month stepping loop
// stops early once the year passes YEAR_MAX. s_tready is high only while
// the sequencer is idle. The result register holds a finished result until
// m_tready takes it, while the next request is already accepted. Reset is
// synchronous.
// ----------------------------------------------------------------------------
module gregorian_date_adder #(
  parameter int YEAR_MAX = 32767
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [gda_pkg::S_DATA_W-1:0] s_tdata,   // year_in, month_in, day_in, amount
  input  logic [1:0]                   s_tuser,   // action
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [gda_pkg::M_DATA_W-1:0] m_tdata,   // year_out, month_out, day_out
  output logic [1:0]                   m_tuser    // error_code
);
  import gda_pkg::*;

  localparam logic [YEAR_W-1:0] YMAX = YEAR_W'(YEAR_MAX);

  state_t state, state_next;

  // Captured request
  logic [1:0]  action;
  logic [14:0] year0;
  logic [3:0]  month0;
  logic [4:0]  day0;
  logic [14:0] amount;

  // Working date
  logic [YEAR_W-1:0] year;
  logic [3:0]        month;
  logic [4:0]        day;
  logic [RES_W-1:0]  res400;
  logic [REM_W-1:0]  rem;
  logic [14:0]       cnt;
  logic [1:0]        err;
  logic              pass;

  // Result register
  logic [14:0] year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic [1:0]  error_code;

  logic              mod_start;
  logic [YEAR_W-1:0] mod_value;
  logic              mod_done;
  logic [RES_W-1:0]  mod_res;

  logic              accept;
  logic              out_free;
  logic              over;
  logic              bad_day;
  logic [4:0]        len_cur;
  logic [4:0]        left;
  logic              wrap;
  logic [3:0]        month_nx;
  logic [RES_W-1:0]  res_nx;
  logic [YEAR_W-1:0] year_nx;
  logic [4:0]        len_nx;
  logic [YEAR_W-1:0] year_sum;

  gda_mod400 u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .value (mod_value),
    .done  (mod_done),
    .res   (mod_res)
  );

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign over     = year > YMAX;
  assign len_cur  = month_days(leap_of(res400), month);
  assign bad_day  = (day == 5'd0) || (day > len_cur);
  assign left     = len_cur - day;
  assign wrap     = month == MONTH_DEC;
  assign month_nx = wrap ? MONTH_JAN : month + 4'd1;
  assign res_nx   = !wrap ? res400 :
                    (res400 == RES_W'(MOD_BASE - 1)) ? '0 : res400 + 1'b1;
  assign year_nx  = year + YEAR_W'(wrap);
  assign len_nx   = month_days(leap_of(res_nx), month_nx);
  assign year_sum = year + YEAR_W'(amount);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_MOD;
      end
      ST_MOD: begin
        if (mod_done) state_next = pass ? ST_YFIX : ST_CHECK;
      end
      ST_CHECK: begin
        if (bad_day || over) begin
          state_next = ST_DONE;
        end else begin
          case (action)
            ACT_DAYS, ACT_WEEKS: state_next = ST_DAYS;
            ACT_MONTHS:          state_next = ST_MONTHS;
            default:             state_next = ST_MOD;
          endcase
        end
      end
      ST_DAYS: begin
        if (over || (rem == '0)) state_next = ST_DONE;
      end
      ST_MONTHS: begin
        if (over || (cnt == '0)) state_next = ST_DONE;
      end
      ST_YFIX: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    s_tready  = 1'b0;
    mod_start = 1'b0;
    mod_value = YEAR_W'(s_tdata[14:0]);
    case (state)
      ST_IDLE: begin
        s_tready  = 1'b1;
        mod_start = s_tvalid;
      end
      ST_CHECK: begin
        mod_start = !bad_day && !over && (action == ACT_YEARS);
        mod_value = year_sum;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          action <= s_tuser;
          year0  <= s_tdata[14:0];
          month0 <= s_tdata[18:15];
          day0   <= s_tdata[23:19];
          amount <= s_tdata[38:24];
          year   <= YEAR_W'(s_tdata[14:0]);
          month  <= s_tdata[18:15];
          day    <= s_tdata[23:19];
          pass   <= 1'b0;
          err    <= ERR_NONE;
        end
      end
      ST_MOD: begin
        if (mod_done) res400 <= mod_res;
      end
      ST_CHECK: begin
        if (bad_day) begin
          err <= ERR_DAY;
        end else if (over) begin
          err <= ERR_YEAR;
        end else begin
          rem  <= (action == ACT_WEEKS) ? (REM_W'({amount, 3'b000}) - REM_W'(amount))
                                        : REM_W'(amount);
          cnt  <= amount;
          pass <= 1'b1;
          if (action == ACT_YEARS) year <= year_sum;
        end
      end
      ST_DAYS: begin
        if (over) begin
          err <= ERR_YEAR;
        end else if (rem != '0) begin
          // Either finish inside this month or jump to the first of the next.
          if (rem > REM_W'(left)) begin
            rem    <= rem - REM_W'(left) - 1'b1;
            day    <= 5'd1;
            month  <= month_nx;
            year   <= year_nx;
            res400 <= res_nx;
          end else begin
            day <= day + rem[4:0];
            rem <= '0;
          end
        end
      end
      ST_MONTHS: begin
        if (over) begin
          err <= ERR_YEAR;
        end else if (cnt != '0) begin
          cnt    <= cnt - 1'b1;
          month  <= month_nx;
          year   <= year_nx;
          res400 <= res_nx;
          if (day > len_nx) day <= len_nx;
        end
      end
      ST_YFIX: begin
        if (over) begin
          err <= ERR_YEAR;
        end else if ((month == MONTH_FEB) && (day == 5'd29) && !leap_of(res400)) begin
          day <= 5'd28;
        end
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      error_code <= err;
      if (err != ERR_NONE) begin
        year_out  <= year0;
        month_out <= month0;
        day_out   <= day0;
      end else begin
        year_out  <= year[14:0];
        month_out <= month;
        day_out   <= day;
      end
    end
  end

  assign m_tdata = {day_out, month_out, year_out};
  assign m_tuser = error_code;

endmodule

// File: src/gda_checker.sv
// ----------------------------------------------------------------------------
// gda_checker: port-level checks for the Gregorian date adder
// Watches the request and result streams and is bound to the top level.
// ----------------------------------------------------------------------------
module gda_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [gda_pkg::M_DATA_W-1:0] m_tdata,
  input logic [1:0]                   m_tuser
);
  import gda_pkg::*;

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // The sequencer is busy after taking a request, so no two are taken back to back.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted on back-to-back cycles");

  a_err_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == ERR_NONE) || (m_tuser == ERR_DAY) || (m_tuser == ERR_YEAR))
    else $error("undefined error code");

  // A good result always carries a month in 1..12 and a nonzero day.
  a_good_date: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ERR_NONE) |->
      (m_tdata[18:15] != 4'd0) && (m_tdata[18:15] <= MONTH_DEC) && (m_tdata[23:19] != 5'd0))
    else $error("result date out of range");

endmodule

bind gregorian_date_adder gda_checker u_gda_checker (.*);

// File: dv/gregorian_date_adder_test.sv
// ----------------------------------------------------------------------------
// gregorian_date_adder_test: self-checking bench for the Gregorian date adder
// Runs a table of directed requests (calendar edges, clamps, leap rules and
// error cases), then randomized requests weighted toward valid dates and
// small amounts. Results are checked in request order, field by field,
// against table rows or a behavioral date model, under random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gregorian_date_adder_test;
  import gda_pkg::*;

  localparam int YEAR_LIMIT   = 32767;
  localparam int RANDOM_COUNT = 555;
  localparam int DIRECTED_N   = 25;

  typedef struct packed {
    logic [1:0]  action;
    logic [14:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [14:0] amount;
  } date_req_t;

  typedef struct packed {
    logic [14:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [1:0]  err;
  } date_res_t;

  typedef struct packed {
    date_req_t req;
    logic      known;
    date_res_t res;
  } directed_row_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic [1:0]          s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;
  logic [1:0]          m_tuser;

  date_res_t     pending_dates[$];
  date_res_t     oldest_date;
  int unsigned   mismatches;
  bit            steady;
  directed_row_t directed_rows[DIRECTED_N];

  gregorian_date_adder DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic bit leap_year(input int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
    int unsigned len;
    case (m)
      1, 3, 5, 7, 8, 10, 12: len = 31;
      4, 6, 9, 11:           len = 30;
      2:                     len = leap_year(y) ? 29 : 28;
      default:               len = 0;
    endcase
    return len;
  endfunction

  // Computes the date that a request should produce, including error echo.
  function automatic date_res_t add_to_date(input date_req_t r);
    date_res_t   res;
    int unsigned y, m, d, rem, left, len;
    y = r.year;
    m = r.month;
    d = r.day;
    res.err = ERR_NONE;
    if (d == 0 || d > month_length(y, m)) begin
      res.err = ERR_DAY;
    end else if (r.action == ACT_DAYS || r.action == ACT_WEEKS) begin
      rem = (r.action == ACT_WEEKS) ? r.amount * 7 : r.amount;
      while (rem > 0) begin
        left = month_length(y, m) - d;
        if (rem > left) begin
          rem -= left + 1;
          d = 1;
          if (m == 12) begin
            y++;
            m = 1;
          end else begin
            m++;
          end
        end else begin
          d += rem;
          rem = 0;
        end
      end
    end else if (r.action == ACT_MONTHS) begin
      // The day clamp carries into every later month.
      for (int unsigned i = 0; i < r.amount; i++) begin
        if (m == 12) begin
          y++;
          m = 1;
        end else begin
          m++;
        end
        len = month_length(y, m);
        if (d > len) d = len;
      end
    end else begin
      y += r.amount;
      if (m == 2 && d == 29 && !leap_year(y)) d = 28;
    end
    if (res.err == ERR_NONE && y > YEAR_LIMIT) res.err = ERR_YEAR;
    if (res.err != ERR_NONE) begin
      y = r.year;
      m = r.month;
      d = r.day;
    end
    res.year  = 15'(y);
    res.month = 4'(m);
    res.day   = 5'(d);
    return res;
  endfunction

  function automatic date_req_t random_request();
    date_req_t   r;
    int unsigned pick, len;
    r.action = 2'($urandom_range(3));
    // Large amounts are slow for months and weeks, so they stay rare.
    pick = $urandom_range(99);
    if (pick < 6) r.amount = 15'($urandom_range(32767));
    else if (pick < 18) r.amount = 15'($urandom_range(2000));
    else r.amount = 15'($urandom_range(60));
    pick = $urandom_range(99);
    if (pick < 5) begin
      r.year  = 15'($urandom);
      r.month = 4'($urandom);
      r.day   = 5'($urandom);
      return r;
    end
    pick = $urandom_range(9);
    if (pick < 2) r.year = 15'($urandom_range(32767, 32700));
    else if (pick == 2) r.year = 15'($urandom_range(32767));
    else if (pick == 3) r.year = 15'(100 * $urandom_range(327));
    else r.year = 15'($urandom_range(2600, 1500));
    r.month = 4'($urandom_range(12, 1));
    len = month_length(r.year, r.month);
    pick = $urandom_range(99);
    if (pick < 10) begin
      r.day = 5'(len);
    end else if (pick < 14) begin
      r.day = (len == 31 || $urandom_range(1) == 0) ? 5'd0 : 5'($urandom_range(31, len + 1));
    end else begin
      r.day = 5'($urandom_range(len, 1));
    end
    return r;
  endfunction

  task automatic send_request(input date_req_t r, input bit known, input date_res_t res);
    while (!steady && $urandom_range(99) < 11) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.action;
    s_tdata  <= {1'b0, r.amount, r.day, r.month, r.year};
    do @(posedge clk); while (!s_tready);
    pending_dates.push_back(known ? res : add_to_date(r));
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= 11);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_dates.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual %0d-%0d-%0d error %0d",
                 $time, m_tdata[14:0], m_tdata[18:15], m_tdata[23:19], m_tuser);
        mismatches++;
      end else begin
        oldest_date = pending_dates.pop_front();
        check_field("year_out", oldest_date.year, m_tdata[14:0]);
        check_field("month_out", oldest_date.month, m_tdata[18:15]);
        check_field("day_out", oldest_date.day, m_tdata[23:19]);
        check_field("error_code", oldest_date.err, m_tuser);
      end
    end
  end

  initial begin
    date_res_t blank;
    blank = '0;
    directed_rows = '{
      '{'{ACT_DAYS,   15'd2024,  4'd1,  5'd1,  15'd0},     1'b1, '{15'd2024,  4'd1,  5'd1,  ERR_NONE}},
      '{'{ACT_DAYS,   15'd2023,  4'd12, 5'd31, 15'd1},     1'b1, '{15'd2024,  4'd1,  5'd1,  ERR_NONE}},
      '{'{ACT_DAYS,   15'd2024,  4'd2,  5'd28, 15'd1},     1'b1, '{15'd2024,  4'd2,  5'd29, ERR_NONE}},
      '{'{ACT_DAYS,   15'd2023,  4'd2,  5'd28, 15'd1},     1'b1, '{15'd2023,  4'd3,  5'd1,  ERR_NONE}},
      '{'{ACT_DAYS,   15'd1900,  4'd2,  5'd28, 15'd1},     1'b1, '{15'd1900,  4'd3,  5'd1,  ERR_NONE}},
      '{'{ACT_DAYS,   15'd2000,  4'd2,  5'd28, 15'd1},     1'b1, '{15'd2000,  4'd2,  5'd29, ERR_NONE}},
      '{'{ACT_WEEKS,  15'd2024,  4'd1,  5'd1,  15'd32767}, 1'b0, blank},
      '{'{ACT_DAYS,   15'd0,     4'd1,  5'd1,  15'd32767}, 1'b0, blank},
      '{'{ACT_MONTHS, 15'd2024,  4'd1,  5'd31, 15'd1},     1'b1, '{15'd2024,  4'd2,  5'd29, ERR_NONE}},
      '{'{ACT_MONTHS, 15'd2024,  4'd1,  5'd31, 15'd2},     1'b1, '{15'd2024,  4'd3,  5'd29, ERR_NONE}},
      '{'{ACT_MONTHS, 15'd2023,  4'd12, 5'd15, 15'd1},     1'b1, '{15'd2024,  4'd1,  5'd15, ERR_NONE}},
      '{'{ACT_MONTHS, 15'd0,     4'd1,  5'd1,  15'd32767}, 1'b0, blank},
      '{'{ACT_YEARS,  15'd2024,  4'd2,  5'd29, 15'd1},     1'b1, '{15'd2025,  4'd2,  5'd28, ERR_NONE}},
      '{'{ACT_YEARS,  15'd2024,  4'd2,  5'd29, 15'd4},     1'b1, '{15'd2028,  4'd2,  5'd29, ERR_NONE}},
      '{'{ACT_YEARS,  15'd0,     4'd1,  5'd1,  15'd32767}, 1'b1, '{15'd32767, 4'd1,  5'd1,  ERR_NONE}},
      '{'{ACT_YEARS,  15'd32767, 4'd12, 5'd31, 15'd1},     1'b1, '{15'd32767, 4'd12, 5'd31, ERR_YEAR}},
      '{'{ACT_DAYS,   15'd32767, 4'd12, 5'd31, 15'd1},     1'b1, '{15'd32767, 4'd12, 5'd31, ERR_YEAR}},
      '{'{ACT_MONTHS, 15'd32767, 4'd12, 5'd1,  15'd32767}, 1'b1, '{15'd32767, 4'd12, 5'd1,  ERR_YEAR}},
      '{'{ACT_DAYS,   15'd2023,  4'd2,  5'd29, 15'd5},     1'b1, '{15'd2023,  4'd2,  5'd29, ERR_DAY}},
      '{'{ACT_DAYS,   15'd2024,  4'd4,  5'd31, 15'd1},     1'b1, '{15'd2024,  4'd4,  5'd31, ERR_DAY}},
      '{'{ACT_MONTHS, 15'd2024,  4'd0,  5'd10, 15'd1},     1'b1, '{15'd2024,  4'd0,  5'd10, ERR_DAY}},
      '{'{ACT_YEARS,  15'd32767, 4'd15, 5'd31, 15'd32767}, 1'b1, '{15'd32767, 4'd15, 5'd31, ERR_DAY}},
      '{'{ACT_DAYS,   15'd2024,  4'd5,  5'd0,  15'd3},     1'b1, '{15'd2024,  4'd5,  5'd0,  ERR_DAY}},
      '{'{ACT_WEEKS,  15'd2024,  4'd12, 5'd25, 15'd1},     1'b1, '{15'd2025,  4'd1,  5'd1,  ERR_NONE}},
      '{'{ACT_YEARS,  15'd32766, 4'd6,  5'd30, 15'd1},     1'b1, '{15'd32767, 4'd6,  5'd30, ERR_NONE}}
    };
    mismatches = 0;
    steady     = 1'b0;
    rst        <= 1'b1;
    s_tvalid   <= 1'b0;
    s_tdata    <= '0;
    s_tuser    <= ACT_DAYS;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].known, directed_rows[i].res);
    end
    drain_results();

    for (int n = 0; n < RANDOM_COUNT; n++) begin
      steady = (n >= 200 && n < 330);
      // Now and then the sender holds off until the block has emptied.
      if (n % 100 == 99) drain_results();
      send_request(random_request(), 1'b0, blank);
    end
    steady = 1'b0;
    drain_results();
    repeat (64) @(posedge clk);

    if (pending_dates.size() != 0) begin
      $display("%0t ns: results missing, expected %0d more, actual 0",
               $time, pending_dates.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: gregorian_date_adder.f
src/gda_pkg.sv
src/gda_mod400.sv
src/gregorian_date_adder.sv
src/gda_checker.sv
dv/gregorian_date_adder_test.sv
